// File: rtl/core/birled_pkg.sv
// Shared types and constants of the binary image run-length decoder.
`default_nettype none

package birled_pkg;

    localparam int LEN_WIDTH_DEF   = 24;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TOTAL_W         = 24;
    localparam int REP_W           = 22;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int MAX_RESULTS     = 3;

    // Register indexes
    localparam logic REG_PIX_TOTAL = 1'b0;

    // Command codes
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Encoded byte fields
    localparam int OP_RUN_BIT   = 7;
    localparam int RUN_VAL_BIT  = 6;
    localparam int RUN_MORE_BIT = 5;
    localparam int MORE_BIT     = 7;

    localparam logic [5:0] FIRST_SHIFT = 6'd5;
    localparam logic [5:0] MAX_SHIFT   = 6'd63;

    typedef enum logic {
        PH_OPCODE,
        PH_COUNT
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       data;
        logic [REP_W-1:0] rep;
    } result_t;

    typedef struct packed {
        logic [1:0]              count;
        logic                    done;
        result_t [MAX_RESULTS-1:0] slot;
    } bundle_t;

endpackage

`default_nettype wire

// File: rtl/core/birled_if.sv
// Stream channel interfaces for encoded bytes and packed pixel results.
`default_nettype none

interface birled_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, output command, output in_byte, input ready);
    modport sink   (input valid, input command, input in_byte, output ready);
endinterface

interface birled_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [21:0] repeat_count;
    logic        image_done;
    logic        last;

    modport source (output valid, output out_byte, output repeat_count,
                    output image_done, output last, input ready);
    modport sink   (input valid, input out_byte, input repeat_count,
                    input image_done, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/birled_cfg.sv
// APB-style configuration register holding the image pixel total.
`default_nettype none

module birled_cfg
    import birled_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [TOTAL_W-1:0]    pix_total
);

    logic [TOTAL_W-1:0] total_reg;
    logic               reg_index;
    logic               wr_en;

    assign reg_index = paddr[CFG_ADDR_W-1];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready
                       && (reg_index == REG_PIX_TOTAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (wr_en)
        begin
            total_reg <= pwdata[TOTAL_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_index == REG_PIX_TOTAL)
        begin
            prdata = CFG_DATA_W'(total_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign pix_total = total_reg;

endmodule

`default_nettype wire

// File: rtl/core/birled_in_stage.sv
// Input register for encoded byte transfers.
`default_nettype none

module birled_in_stage
    import birled_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    birled_in_if.sink     enc,
    input  wire logic     advance,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    in_item_t item_reg;
    logic     take;

    assign enc.ready = !valid_reg || advance;
    assign take      = enc.valid && enc.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{command: enc.command, in_byte: enc.in_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: rtl/core/birled_decode.sv
// Decoder state and single-pass decode of one encoded byte into up to three results.
`default_nettype none

module birled_decode
    import birled_pkg::*;
#(
    parameter int LEN_WIDTH   = LEN_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire in_item_t           item,
    input  wire logic [TOTAL_W-1:0] pix_total,
    output bundle_t                 bundle_next
);

    localparam int CMP_W = (COUNT_WIDTH + 1 > LEN_WIDTH) ? COUNT_WIDTH + 1 : LEN_WIDTH;

    phase_t                 phase_reg,        phase_next;
    logic                   run_value_reg,    run_value_next;
    logic [COUNT_WIDTH-1:0] run_length_reg,   run_length_next;
    logic [5:0]             count_shift_reg,  count_shift_next;
    logic [7:0]             partial_byte_reg, partial_byte_next;
    logic [2:0]             filled_bits_reg,  filled_bits_next;
    logic [LEN_WIDTH-1:0]   pixels_out_reg,   pixels_out_next;

    logic [31:0]            total_ext;
    logic [LEN_WIDTH-1:0]   total_len;
    logic [LEN_WIDTH-1:0]   rem;
    logic                   active;
    logic                   restart;
    logic [7:0]             b;

    logic [COUNT_WIDTH-1:0] acc_len;
    logic [6:0]             cs_sum;
    logic [5:0]             cs_sat;
    logic                   do_lit;
    logic                   do_run;
    logic                   run_v;
    logic [COUNT_WIDTH-1:0] run_len_sel;

    logic [CMP_W-1:0]       len_ext;
    logic [CMP_W-1:0]       rem_ext;
    logic [LEN_WIDTH-1:0]   n_run;
    logic [3:0]             room;
    logic [3:0]             head_len;
    logic [3:0]             fill_sum;
    logic [7:0]             head_byte;
    logic                   head_emit;
    logic [LEN_WIDTH-1:0]   n_after;
    logic [31:0]            n_after_ext;
    logic                   fill_emit;
    logic [REP_W-1:0]       fill_rep;
    logic [2:0]             tail_t;

    logic [2:0]             n_lit;
    logic [6:0]             lit_bits;
    logic [15:0]            window;
    logic [3:0]             lit_sum;

    logic [7:0]             partial_mid;
    logic [2:0]             filled_mid;
    logic [LEN_WIDTH-1:0]   pix_mid;
    logic                   a_valid, b_valid, c_valid;
    result_t                a_res,   b_res,   c_res;

    assign b         = item.in_byte;
    assign restart   = (item.command == CMD_RESTART);
    assign total_ext = 32'(pix_total);
    assign total_len = total_ext[LEN_WIDTH-1:0];
    assign active    = pixels_out_reg < total_len;
    assign rem       = total_len - pixels_out_reg;

    assign acc_len = run_length_reg | (COUNT_WIDTH'(b[6:0]) << count_shift_reg);
    assign cs_sum  = {1'b0, count_shift_reg} + 7'd7;
    assign cs_sat  = (cs_sum > {1'b0, MAX_SHIFT}) ? MAX_SHIFT : cs_sum[5:0];

    // Phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (restart)
        begin
            phase_next = PH_OPCODE;
        end
        else if (active)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    if (!b[MORE_BIT])
                    begin
                        phase_next = PH_OPCODE;
                    end
                end
                PH_OPCODE:
                begin
                    if (b[OP_RUN_BIT] && b[RUN_MORE_BIT])
                    begin
                        phase_next = PH_COUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_OPCODE;
                end
            endcase
        end
    end

    // Count accumulation and path selection
    always_comb
    begin
        run_value_next   = run_value_reg;
        run_length_next  = run_length_reg;
        count_shift_next = count_shift_reg;
        do_lit           = 1'b0;
        do_run           = 1'b0;
        run_v            = b[RUN_VAL_BIT];
        run_len_sel      = COUNT_WIDTH'(b[4:0]);
        if (restart)
        begin
            run_value_next   = 1'b0;
            run_length_next  = '0;
            count_shift_next = '0;
        end
        else if (active)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    run_length_next  = acc_len;
                    count_shift_next = cs_sat;
                    run_v            = run_value_reg;
                    run_len_sel      = acc_len;
                    do_run           = !b[MORE_BIT];
                end
                PH_OPCODE:
                begin
                    if (!b[OP_RUN_BIT])
                    begin
                        do_lit = 1'b1;
                    end
                    else
                    begin
                        run_value_next  = b[RUN_VAL_BIT];
                        run_length_next = COUNT_WIDTH'(b[4:0]);
                        if (b[RUN_MORE_BIT])
                        begin
                            count_shift_next = FIRST_SHIFT;
                        end
                        else
                        begin
                            do_run = 1'b1;
                        end
                    end
                end
                default:
                begin
                    do_lit = 1'b0;
                end
            endcase
        end
    end

    // Run path: head of the partial byte, fill bytes, tail bits
    assign len_ext   = CMP_W'(run_len_sel) + CMP_W'(8);
    assign rem_ext   = CMP_W'(rem);
    assign n_run     = (len_ext < rem_ext) ? len_ext[LEN_WIDTH-1:0] : rem;
    assign room      = 4'd8 - {1'b0, filled_bits_reg};

    always_comb
    begin
        if (filled_bits_reg == 3'd0)
        begin
            head_len = 4'd0;
        end
        else if (n_run >= LEN_WIDTH'(room))
        begin
            head_len = room;
        end
        else
        begin
            head_len = n_run[3:0];
        end
    end

    assign fill_sum    = {1'b0, filled_bits_reg} + head_len;
    assign head_byte   = partial_byte_reg
                         | (run_v ? ((8'hFF >> filled_bits_reg) & ~(8'hFF >> fill_sum))
                                  : 8'h00);
    assign head_emit   = (fill_sum == 4'd8);
    assign n_after     = n_run - LEN_WIDTH'(head_len);
    assign n_after_ext = 32'(n_after);
    assign fill_emit   = (n_after[LEN_WIDTH-1:3] != '0);
    assign fill_rep    = n_after_ext[REP_W+2:3];
    assign tail_t      = n_after[2:0];

    // Literal path
    assign n_lit    = (rem < LEN_WIDTH'(7)) ? rem[2:0] : 3'd7;
    assign lit_bits = b[6:0] & ~(7'h7F >> n_lit);
    assign window   = {partial_byte_reg, 8'h00} | ({lit_bits, 9'b0} >> filled_bits_reg);
    assign lit_sum  = {1'b0, filled_bits_reg} + {1'b0, n_lit};

    always_comb
    begin
        partial_mid = partial_byte_reg;
        filled_mid  = filled_bits_reg;
        pix_mid     = pixels_out_reg;
        a_valid     = 1'b0;
        b_valid     = 1'b0;
        c_valid     = 1'b0;
        a_res       = '{data: window[15:8], rep: REP_W'(1)};
        b_res       = '{data: (run_v ? 8'hFF : 8'h00), rep: fill_rep};
        c_res       = '{data: 8'h00, rep: REP_W'(1)};

        if (do_lit)
        begin
            pix_mid    = pixels_out_reg + LEN_WIDTH'(n_lit);
            a_valid    = lit_sum[3];
            filled_mid = lit_sum[2:0];
            if (lit_sum[3])
            begin
                partial_mid = window[7:0];
            end
            else
            begin
                partial_mid = window[15:8];
            end
        end
        else if (do_run)
        begin
            pix_mid = pixels_out_reg + n_run;
            a_valid = head_emit;
            a_res   = '{data: head_byte, rep: REP_W'(1)};
            b_valid = fill_emit;
            if (head_emit || (filled_bits_reg == 3'd0))
            begin
                partial_mid = run_v ? ~(8'hFF >> tail_t) : 8'h00;
                filled_mid  = tail_t;
            end
            else
            begin
                partial_mid = head_byte;
                filled_mid  = fill_sum[2:0];
            end
        end

        partial_byte_next = partial_mid;
        filled_bits_next  = filled_mid;
        pixels_out_next   = pix_mid;

        // Flush the last partial byte once the image is complete
        if ((pix_mid >= total_len) && (filled_mid != 3'd0))
        begin
            c_valid           = 1'b1;
            c_res             = '{data: partial_mid, rep: REP_W'(1)};
            partial_byte_next = 8'h00;
            filled_bits_next  = 3'd0;
        end

        if (restart)
        begin
            a_valid           = 1'b0;
            b_valid           = 1'b0;
            c_valid           = 1'b0;
            partial_byte_next = 8'h00;
            filled_bits_next  = 3'd0;
            pixels_out_next   = '0;
        end
    end

    // Pack results in order
    always_comb
    begin
        bundle_next.count   = 2'({1'b0, a_valid} + {1'b0, b_valid} + {1'b0, c_valid});
        bundle_next.done    = (pixels_out_next >= total_len) && !restart;
        bundle_next.slot[2] = c_res;
        bundle_next.slot[1] = (a_valid && b_valid) ? b_res : c_res;
        if (a_valid)
        begin
            bundle_next.slot[0] = a_res;
        end
        else if (b_valid)
        begin
            bundle_next.slot[0] = b_res;
        end
        else
        begin
            bundle_next.slot[0] = c_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_OPCODE;
            run_value_reg    <= 1'b0;
            run_length_reg   <= '0;
            count_shift_reg  <= '0;
            partial_byte_reg <= '0;
            filled_bits_reg  <= '0;
            pixels_out_reg   <= '0;
        end
        else if (load)
        begin
            phase_reg        <= phase_next;
            run_value_reg    <= run_value_next;
            run_length_reg   <= run_length_next;
            count_shift_reg  <= count_shift_next;
            partial_byte_reg <= partial_byte_next;
            filled_bits_reg  <= filled_bits_next;
            pixels_out_reg   <= pixels_out_next;
        end
    end

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load && (item.command == CMD_RESTART)
        |=> (pixels_out_reg == '0) && (filled_bits_reg == 3'd0) && (phase_reg == PH_OPCODE))
        else $error("restart left decoder state behind");

    a_unfilled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (partial_byte_reg & (8'hFF >> filled_bits_reg)) == 8'h00)
        else $error("unfilled bits of partial byte are set");

endmodule

`default_nettype wire

// File: rtl/core/birled_out_stage.sv
// Result register that hands out up to three results of one byte, one per transfer.
`default_nettype none

module birled_out_stage
    import birled_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire bundle_t  bundle_next,
    output logic          can_load,
    birled_out_if.source  pix
);

    logic [1:0]                count_reg;
    logic                      done_reg;
    logic [1:0]                idx_reg;
    result_t [MAX_RESULTS-1:0] slot_reg;
    result_t                   cur;
    logic                      is_last;
    logic                      transfer;

    assign is_last  = (idx_reg == count_reg - 2'd1);
    assign transfer = pix.valid && pix.ready;
    assign can_load = (count_reg == 2'd0) || (transfer && is_last);
    assign cur      = slot_reg[idx_reg];

    assign pix.valid        = (count_reg != 2'd0);
    assign pix.out_byte     = cur.data;
    assign pix.repeat_count = cur.rep;
    assign pix.image_done   = done_reg && is_last;
    assign pix.last         = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            done_reg  <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= bundle_next.count;
            done_reg  <= bundle_next.done;
            idx_reg   <= 2'd0;
        end
        else if (transfer)
        begin
            if (is_last)
            begin
                count_reg <= 2'd0;
                idx_reg   <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= bundle_next.slot;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd0) |-> (idx_reg < count_reg))
        else $error("result index beyond held results");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load && (bundle_next.count != 2'd0) |=> pix.valid && (idx_reg == 2'd0))
        else $error("loaded results not presented from the first");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        transfer && is_last && !load |=> !pix.valid)
        else $error("results remain after the final transfer");

endmodule

`default_nettype wire

// File: rtl/core/binary_image_rle_decoder_unit.sv
// Top level of the binary image run-length decoder.
// Decodes a 1 bit per pixel run-length stream, one encoded byte per cycle while the result
// port keeps up, into packed pixel bytes given as (byte, repeat count) results. A byte is
// held in the input register, decoded combinationally and its results (none to three) loaded
// into the result register, which gives them out on the single result port one per transfer.
// A byte giving r results holds the result port until all r are taken, so throughput is one
// byte per cycle while each byte gives at most one result and the receiver is ready. Set the
// pixel total register while idle, then send a restart command before each image.
`default_nettype none

module binary_image_rle_decoder_unit
    import birled_pkg::*;
#(
    parameter int LEN_WIDTH   = LEN_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    birled_in_if.sink                  enc,
    birled_out_if.source               pix,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic               item_valid;
    in_item_t           item;
    logic               can_load;
    logic               advance;
    bundle_t            bundle_next;
    logic [TOTAL_W-1:0] pix_total;

    assign advance = item_valid && can_load;

    birled_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_total (pix_total)
    );

    birled_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .enc        (enc),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    birled_decode #(
        .LEN_WIDTH   (LEN_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .item        (item),
        .pix_total   (pix_total),
        .bundle_next (bundle_next)
    );

    birled_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .bundle_next (bundle_next),
        .can_load    (can_load),
        .pix         (pix)
    );

endmodule

`default_nettype wire

// File: tb/binary_image_rle_decoder_unit_tb.sv
// Self-checking testbench for the binary image run-length decoder unit.
`timescale 1ns / 1ps

module binary_image_rle_decoder_unit_tb;
    import birled_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASES        = 8;
    localparam int PHASE_QUOTA   = 28;
    localparam logic [CFG_ADDR_W-1:0] TOTAL_ADDR = CFG_ADDR_W'(4 * int'(REG_PIX_TOTAL));
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic [7:0]       data;
        logic [REP_W-1:0] rep;
        logic             done;
        logic             last;
    } pixel_run_t;

    class pixel_ledger;
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] pix_out;
        phase_t             phase;
        logic               run_val;
        logic [31:0]        run_len;
        logic [5:0]         shift;
        logic [7:0]         part;
        logic [2:0]         filled;
        pixel_run_t         expected_pixels[$];
        pixel_run_t         fresh[$];
        int                 errors;

        function new();
            total  = '0;
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase   = PH_OPCODE;
            run_val = 1'b0;
            run_len = '0;
            shift   = '0;
            part    = '0;
            filled  = '0;
            pix_out = '0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function void put(logic [7:0] b, int unsigned rep);
            pixel_run_t r;
            r.data = b;
            r.rep  = rep[REP_W-1:0];
            r.done = 1'b0;
            r.last = 1'b0;
            fresh.push_back(r);
        endfunction

        // pack n pixels held MSB first in the low n bits of b
        function void push_bits(int unsigned b, int unsigned n);
            int unsigned room;
            int unsigned rest;
            room = 8 - filled;
            if (n >= room)
            begin
                rest = n - room;
                part = part | 8'(b >> rest);
                put(part, 1);
                part = 8'((b & ((1 << rest) - 1)) << (8 - rest));
                filled = 3'(rest);
            end
            else
            begin
                part = part | 8'(b << (room - n));
                filled = filled + 3'(n);
            end
        endfunction

        function void emit_run(logic v, int unsigned n);
            int unsigned h;
            pix_out = pix_out + TOTAL_W'(n);
            if (filled != 0)
            begin
                h = 8 - filled;
                if (h > n)
                    h = n;
                push_bits(v ? (1 << h) - 1 : 0, h);
                n = n - h;
            end
            if ((n >> 3) != 0)
                put(v ? 8'hFF : 8'h00, n >> 3);
            n = n & 7;
            if (n != 0)
                push_bits(v ? (1 << n) - 1 : 0, n);
        endfunction

        function void start_run(int unsigned rem);
            logic [32:0] span;
            span = {1'b0, run_len} + 33'd8;
            if (span < 33'(rem))
                emit_run(run_val, span[31:0]);
            else
                emit_run(run_val, rem);
            phase = PH_OPCODE;
        endfunction

        // returns 1 when the transfer is not merely ignored
        function bit take_byte(logic cmd, logic [7:0] code);
            int unsigned rem;
            int unsigned n;
            logic [63:0] grp;
            bit          live;
            fresh.delete();
            if (cmd == CMD_RESTART)
            begin
                clear();
                return 1'b1;
            end
            live = pix_out < total;
            if (live)
            begin
                rem = total - pix_out;
                if (phase == PH_COUNT)
                begin
                    grp = 64'(code[6:0]) << shift;
                    run_len = run_len | grp[31:0];
                    shift = (shift > MAX_SHIFT - 6'd7) ? MAX_SHIFT : shift + 6'd7;
                    if (!code[MORE_BIT])
                        start_run(rem);
                end
                else if (!code[OP_RUN_BIT])
                begin
                    n = (rem < 7) ? rem : 7;
                    pix_out = pix_out + TOTAL_W'(n);
                    push_bits(code[6:0] >> (7 - n), n);
                end
                else
                begin
                    run_val = code[RUN_VAL_BIT];
                    run_len = {27'd0, code[4:0]};
                    if (code[RUN_MORE_BIT])
                    begin
                        phase = PH_COUNT;
                        shift = FIRST_SHIFT;
                    end
                    else
                        start_run(rem);
                end
            end
            if (pix_out >= total && filled != 0)
            begin
                put(part, 1);
                part   = '0;
                filled = '0;
            end
            if (fresh.size() != 0)
            begin
                if (pix_out >= total)
                    fresh[fresh.size() - 1].done = 1'b1;
                fresh[fresh.size() - 1].last = 1'b1;
                foreach (fresh[i])
                    expected_pixels.push_back(fresh[i]);
            end
            return live;
        endfunction

        task match_result(logic [7:0] data, logic [REP_W-1:0] rep, logic done, logic last);
            pixel_run_t want;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("unexpected result byte %02h repeat %0d", data, rep));
                return;
            end
            want = expected_pixels.pop_front();
            if (data !== want.data)
                report($sformatf("out_byte %02h, want %02h", data, want.data));
            if (rep !== want.rep)
                report($sformatf("repeat_count %0d, want %0d", rep, want.rep));
            if (done !== want.done)
                report($sformatf("image_done %0b, want %0b", done, want.done));
            if (last !== want.last)
                report($sformatf("last %0b, want %0b", last, want.last));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    birled_in_if  enc_ch ();
    birled_out_if pix_ch ();

    pixel_ledger ledger;
    bit          idle_on;
    bit          hold_req;
    bit          hold_off;
    int          fed;

    binary_image_rle_decoder_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .enc     (enc_ch),
        .pix     (pix_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // long receiver hold-off, so the decoder fills and stalls its input
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(negedge clk)
    begin
        pix_ch.ready = !hold_off && !(idle_on && $urandom_range(0, 99) < 15);
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_ch.valid && pix_ch.ready)
            ledger.match_result(pix_ch.out_byte, pix_ch.repeat_count,
                                pix_ch.image_done, pix_ch.last);
    end

    task automatic send_item(input logic cmd, input logic [7:0] code);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 15)
        begin
            enc_ch.valid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        enc_ch.valid   = 1'b1;
        enc_ch.command = cmd;
        enc_ch.in_byte = code;
        do
            @(posedge clk);
        while (!enc_ch.ready);
        if (ledger.take_byte(cmd, code))
            fed++;
    endtask

    // drop valid and wait for every pending transfer to drain
    task automatic settle();
        @(negedge clk);
        enc_ch.valid = 1'b0;
        while (ledger.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(input logic [TOTAL_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = TOTAL_ADDR;
        pwdata  = CFG_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        ledger.total = value;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[TOTAL_W-1:0] !== value)
            ledger.report($sformatf("pixel total reads %0d, want %0d",
                                    prdata[TOTAL_W-1:0], value));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_sequence();
        int pick;
        int extra;
        pick = $urandom_range(0, 99);
        if (ledger.pix_out >= ledger.total)
        begin
            if (pick < 50)
                send_item(CMD_BYTE, 8'($urandom));
            send_item(CMD_RESTART, 8'($urandom));
        end
        else if (pick < 35)
            send_item(CMD_BYTE, {1'b0, 7'($urandom)});
        else if (pick < 60)
            send_item(CMD_BYTE, {1'b1, 1'($urandom), 1'b0, 5'($urandom)});
        else if (pick < 82)
        begin
            send_item(CMD_BYTE, {1'b1, 1'($urandom), 1'b1, 5'($urandom)});
            extra = (pick < 72) ? 0 : $urandom_range(1, 3);
            repeat (extra) send_item(CMD_BYTE, {1'b1, 7'($urandom)});
            send_item(CMD_BYTE, {1'b0, 7'($urandom)});
        end
        else if (pick < 92)
            send_item(CMD_BYTE, 8'($urandom));
        else if (pick < 96)
        begin
            send_item(CMD_BYTE, {1'b1, 1'($urandom), 1'b1, 5'($urandom)});
            send_item(CMD_RESTART, 8'($urandom));
        end
        else
            send_item(CMD_RESTART, 8'($urandom));
    endtask

    initial
    begin : stimulus
        logic [7:0]         image_b[$];
        logic [TOTAL_W-1:0] value;
        int                 start;
        int                 pick;

        ledger         = new();
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        fed            = 0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        enc_ch.valid   = 1'b0;
        enc_ch.command = CMD_BYTE;
        enc_ch.in_byte = '0;
        pix_ch.ready   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty image: nothing may come out
        write_total('0);
        send_item(CMD_RESTART, 8'h00);
        send_item(CMD_BYTE, 8'h7F);
        send_item(CMD_BYTE, 8'hC0);

        settle();
        write_total(TOTAL_MAX);
        send_item(CMD_RESTART, 8'hFF);
        image_b = '{8'h00, 8'h7F, 8'h55, 8'h9F, 8'hC0,
                    8'hE1, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h00,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                    8'h2A};
        foreach (image_b[i])
            send_item(CMD_BYTE, image_b[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            pick = $urandom_range(0, 99);
            if (p == 0)
                value = TOTAL_MAX;
            else if (p == 1)
                value = 1;
            else if (p == 3)
                value = TOTAL_W'($urandom_range(2000, 100000));
            else if (pick < 40)
                value = TOTAL_W'($urandom_range(1, 64));
            else if (pick < 70)
                value = TOTAL_W'($urandom_range(65, 2000));
            else if (pick < 85)
                value = TOTAL_W'($urandom_range(2001, 16777214));
            else
                value = TOTAL_MAX;
            settle();
            write_total(value);
            idle_on  = (p != 2);
            hold_req = hold_req || (p == 3);
            start    = fed;
            send_item(CMD_RESTART, 8'($urandom));
            while (fed - start < PHASE_QUOTA)
                send_sequence();
            idle_on = 1'b1;

            // lower the total to at most the pixels already out, mid-image
            if ((p == 0 || $urandom_range(0, 99) < 40) && ledger.pix_out != 0
                && ledger.pix_out < ledger.total)
            begin
                settle();
                write_total(TOTAL_W'($urandom_range(0, ledger.pix_out)));
                send_item(CMD_BYTE, 8'($urandom));
            end
        end

        settle();
        if (ledger.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
